@@ sv/assert_macros.svh @@
// Assertion macros shared by the quote-aware search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while in reset.
`define QASS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that one condition implies another in the same cycle.
`define QASS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `QASS_ASSERT(lbl, (ante) |-> (cons), msg)

// Check that one condition implies another in the next cycle.
`define QASS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `QASS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ sv/qass_pkg.sv @@
// Shared constants and types of the quote-aware substring search.
`default_nettype none

package qass_pkg;

  localparam int PATTERN_MAX   = 8;
  localparam int POSITION_BITS = 16;
  localparam int COUNT_BITS    = POSITION_BITS + 1;
  localparam int LEN_BITS      = 4;
  localparam int CHAR_BITS     = 8;
  localparam int PAT_BITS      = 64;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [CHAR_BITS-1:0] QUOTE_SINGLE = 8'h27;
  localparam logic [CHAR_BITS-1:0] QUOTE_DOUBLE = 8'h22;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PATTERN_LEN   = 2'd0,
    CFG_PATTERN_BYTES = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                     found;
    logic [POSITION_BITS-1:0] position;
    logic                     too_long;
  } result_t;

endpackage

`default_nettype wire

@@ sv/qass_out_buf.sv @@
// Two-entry result buffer between the search core and the output channel.
`default_nettype none

module qass_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire qass_pkg::result_t data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output qass_pkg::result_t     data_o,
  input  wire logic             pop_ready_i
);

  logic [1:0]        count_q, count_d;
  qass_pkg::result_t head_q, head_d;
  qass_pkg::result_t tail_q, tail_d;
  logic              pop;

  assign valid_o = (count_q != 2'd0);
  assign ready_o = (count_q != 2'd2);
  assign data_o  = head_q;
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    if (push_i && !pop) begin
      // append behind what is stored
      if (count_q == 2'd0) begin
        head_d = data_i;
      end else begin
        tail_d = data_i;
      end
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      head_d  = tail_q;
      count_d = count_q - 2'd1;
    end else if (pop && push_i) begin
      if (count_q == 2'd1) begin
        head_d = data_i;
      end else begin
        head_d = tail_q;
        tail_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

`default_nettype wire

@@ sv/quote_aware_substring_search.sv @@
// Top level of the quote-aware substring search.
`default_nettype none
`include "assert_macros.svh"

// Streams a text string in one character per transfer and reports, on the
// transfer marked last_char_i, whether the configured pattern starts at some
// position outside single- or double-quoted text, and the first such start.
// Each quote character toggles its own flag, even inside the other kind of
// quote; quote characters and quoted positions never start a match, but a
// match may run on into quoted text. A pattern length of 0 reports found at
// position 0; lengths above 8 act as 8. Positions saturate at 65535, and
// too_long_o flags a last character whose index lay beyond that range.
// Rate: one character per clock cycle. The window compare runs in the same
// cycle the character is taken, from the character window registers into
// the result buffer; a result appears in the cycle after its last character.
// The two-entry result buffer lets input keep flowing while a result waits;
// input stalls only while both entries hold results not yet taken.
// Configuration writes (index 0: pattern length, index 1: pattern bytes,
// first character in the low byte) are always accepted and are expected
// between strings; other indexes are ignored.
module quote_aware_substring_search (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration write channel
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [qass_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  wire logic [qass_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  // character input channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [qass_pkg::CHAR_BITS-1:0]        char_code_i,
  input  wire logic                                  last_char_i,
  // result output channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       found_o,
  output logic [qass_pkg::POSITION_BITS-1:0]         position_o,
  output logic                                       too_long_o
);

  localparam int P  = qass_pkg::PATTERN_MAX;
  localparam int PB = qass_pkg::POSITION_BITS;

  // configuration registers
  logic [qass_pkg::LEN_BITS-1:0]  pat_len_q;
  logic [qass_pkg::PAT_BITS-1:0]  pat_bytes_q;

  // per-string state: character window, start flags and start positions
  logic [qass_pkg::CHAR_BITS-1:0] win_q  [P];
  logic [qass_pkg::CHAR_BITS-1:0] win_d  [P];
  logic                           elig_q [P];
  logic                           elig_d [P];
  logic [PB-1:0]                  sidx_q [P];
  logic [PB-1:0]                  sidx_d [P];
  logic                           sq_q, sq_d;
  logic                           dq_q, dq_d;
  logic [qass_pkg::COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                           seen_q, seen_d;
  logic [PB-1:0]                  start_q, start_d;

  logic                           in_xfer;
  logic                           buf_ready;
  logic                           is_quote;
  logic [PB-1:0]                  pos_cur;
  logic [qass_pkg::LEN_BITS-1:0]  len_eff;
  logic                           new_hit;
  logic [PB-1:0]                  new_start;
  logic                           ok;
  qass_pkg::result_t              res_d;
  qass_pkg::result_t              res_o;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = buf_ready;
  assign in_xfer     = in_valid_i && in_ready_o;

  // Hold the configuration; drop writes to unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= qass_pkg::LEN_BITS'(1);
      pat_bytes_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        qass_pkg::CFG_PATTERN_LEN: begin
          pat_len_q <= cfg_data_i[qass_pkg::LEN_BITS-1:0];
        end
        qass_pkg::CFG_PATTERN_BYTES: begin
          pat_bytes_q <= cfg_data_i[qass_pkg::PAT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    // Clamp the pattern length to the window depth.
    if (pat_len_q > qass_pkg::LEN_BITS'(P)) begin
      len_eff = qass_pkg::LEN_BITS'(P);
    end else begin
      len_eff = pat_len_q;
    end

    // Saturate the index of this character.
    pos_cur = cnt_q[PB] ? {PB{1'b1}} : cnt_q[PB-1:0];
    cnt_d   = cnt_q[PB] ? cnt_q : cnt_q + qass_pkg::COUNT_BITS'(1);

    // Toggle each quote flag on its own character.
    is_quote = (char_code_i == qass_pkg::QUOTE_SINGLE) ||
               (char_code_i == qass_pkg::QUOTE_DOUBLE);
    sq_d = sq_q ^ (char_code_i == qass_pkg::QUOTE_SINGLE);
    dq_d = dq_q ^ (char_code_i == qass_pkg::QUOTE_DOUBLE);

    // Advance the window by one character; the newest sits in the top slot.
    for (int k = 0; k < P - 1; k++) begin
      win_d[k]  = win_q[k+1];
      elig_d[k] = elig_q[k+1];
      sidx_d[k] = sidx_q[k+1];
    end
    win_d[P-1]  = char_code_i;
    elig_d[P-1] = !is_quote && !sq_q && !dq_q;
    sidx_d[P-1] = pos_cur;

    // For each possible length, the match would start in slot P - L.
    new_hit   = 1'b0;
    new_start = '0;
    for (int l = 1; l <= P; l++) begin
      ok = elig_d[P-l];
      for (int j = 0; j < l; j++) begin
        if (win_d[P-l+j] != pat_bytes_q[8*j +: 8]) begin
          ok = 1'b0;
        end
      end
      if (len_eff == qass_pkg::LEN_BITS'(l)) begin
        new_hit   = ok;
        new_start = sidx_d[P-l];
      end
    end

    // Keep only the first completed match.
    seen_d  = seen_q || new_hit;
    start_d = (!seen_q && new_hit) ? new_start : start_q;

    // Result for a last character; an empty pattern matches at the start.
    res_d.too_long = cnt_q[PB];
    if (len_eff == '0) begin
      res_d.found    = 1'b1;
      res_d.position = '0;
    end else begin
      res_d.found    = seen_d;
      res_d.position = seen_d ? start_d : '0;
    end
  end

  // Advance the string state on each transfer; clear it after the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < P; k++) begin
        win_q[k]  <= '0;
        elig_q[k] <= 1'b0;
        sidx_q[k] <= '0;
      end
      sq_q    <= 1'b0;
      dq_q    <= 1'b0;
      cnt_q   <= '0;
      seen_q  <= 1'b0;
      start_q <= '0;
    end else if (in_xfer) begin
      if (last_char_i) begin
        for (int k = 0; k < P; k++) begin
          win_q[k]  <= '0;
          elig_q[k] <= 1'b0;
          sidx_q[k] <= '0;
        end
        sq_q    <= 1'b0;
        dq_q    <= 1'b0;
        cnt_q   <= '0;
        seen_q  <= 1'b0;
        start_q <= '0;
      end else begin
        for (int k = 0; k < P; k++) begin
          win_q[k]  <= win_d[k];
          elig_q[k] <= elig_d[k];
          sidx_q[k] <= sidx_d[k];
        end
        sq_q    <= sq_d;
        dq_q    <= dq_d;
        cnt_q   <= cnt_d;
        seen_q  <= seen_d;
        start_q <= start_d;
      end
    end
  end

  qass_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer && last_char_i),
    .data_i      (res_d),
    .ready_o     (buf_ready),
    .valid_o     (out_valid_o),
    .data_o      (res_o),
    .pop_ready_i (out_ready_i)
  );

  assign found_o    = res_o.found;
  assign position_o = res_o.position;
  assign too_long_o = res_o.too_long;

  `QASS_ASSERT_NEXT(a_last_gives_result, in_xfer && last_char_i, out_valid_o, "last character gave no result")
  `QASS_ASSERT_IMPLIES(a_stall_only_full, !in_ready_o, out_valid_o, "input stalled with no result pending")
  `QASS_ASSERT_IMPLIES(a_no_match_pos_zero, out_valid_o && !found_o, position_o == '0, "position set without a match")
  `QASS_ASSERT(a_count_saturates, !(cnt_q[PB] && (cnt_q[PB-1:0] != '0)), "character count passed saturation")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the quote-aware substring search block.
`timescale 1ns / 100ps

// Sends text strings into the block one character per transfer and checks
// every search result against a predictor that runs beside the block.
//
// A driver and a monitor run as clocked always blocks. The driver takes
// characters from a queue of pending characters that the stimulus process
// fills. The driver changes inputs at the falling edge. The monitor samples
// at the rising edge, feeds each accepted character to the predictor, and
// compares each accepted result with the oldest predicted one.
//
// Stimulus runs in phases. Pattern registers change only once every
// predicted result has come back. The phases are:
//   - short directed strings: reset pattern, NUL character, quoted and
//     unquoted matches, a match that runs on into a quote, a quote of one
//     kind inside the other kind, an incomplete match at the end, an empty
//     pattern, an oversized length, an all-ones pattern, spare indexes
//   - a burst of one-character strings while the receiver holds off
//   - two very long strings around the position counter's saturation point
//   - random phases, each with its own pattern. About half the strings carry
//     a planted copy of the pattern, about a quarter a copy cut short by the
//     end of the string, and the rest are plain noise.
module tb;
  import qass_pkg::*;

  localparam int POS_LIMIT   = (1 << POSITION_BITS) - 1;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASES      = 8;

  // Spare register indexes; the block must ignore writes to them.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [CHAR_BITS-1:0] code;
    logic                 is_last;
  } text_char_t;

  // Clock, reset and the inputs of the block, all known from time zero.
  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     cfg_valid   = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data    = '0;
  logic                     in_valid    = 1'b0;
  logic [CHAR_BITS-1:0]     char_code   = '0;
  logic                     last_char   = 1'b0;
  logic                     out_ready   = 1'b0;
  logic                     cfg_ready;
  logic                     in_ready;
  logic                     out_valid;
  logic                     found;
  logic [POSITION_BITS-1:0] position;
  logic                     too_long;

  // Characters waiting for the driver, and search results still owed.
  text_char_t text_q  [$];
  result_t    match_q [$];

  // Bookkeeping between the stimulus process, driver and monitor.
  bit char_moved;
  bit idle_on = 1'b1;
  int chars_pushed, chars_taken, strings_pushed, results_checked, writes_done;
  int errors;
  int send_gap, recv_gap, hold_left;
  int hold_asked, hold_served;
  int phase_len [PHASES] = '{2, 0, 8, 3, 15, 1, 5, 4};

  // Predictor copy of the pattern registers, at their reset values.
  logic [LEN_BITS-1:0] pat_len   = 4'd1;
  logic [PAT_BITS-1:0] pat_bytes = '0;

  // Predictor copy of the per-string search state.
  logic [CHAR_BITS-1:0]     win_char [PATTERN_MAX];
  bit                       win_open [PATTERN_MAX];
  logic [POSITION_BITS-1:0] win_pos  [PATTERN_MAX];
  bit                       in_sq, in_dq, hit;
  logic [COUNT_BITS-1:0]    char_idx;
  logic [POSITION_BITS-1:0] hit_pos;

  quote_aware_substring_search DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .char_code_i (char_code),
    .last_char_i (last_char),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .found_o     (found),
    .position_o  (position),
    .too_long_o  (too_long)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drop everything the search remembers about the current string.
  task automatic clear_scan();
    int k;
    for (k = 0; k < PATTERN_MAX; k++) begin
      win_char[k] = '0;
      win_open[k] = 1'b0;
      win_pos[k]  = '0;
    end
    in_sq    = 1'b0;
    in_dq    = 1'b0;
    hit      = 1'b0;
    hit_pos  = '0;
    char_idx = '0;
  endtask

  // Advance the search by one character; on the last one, queue the result.
  task automatic scan_char(input logic [CHAR_BITS-1:0] c, input logic fin);
    logic [POSITION_BITS-1:0] pos;
    bit                       quote, same, over;
    int                       len, s, j, k;
    result_t                  r;
    over  = char_idx > POS_LIMIT;
    pos   = over ? '1 : char_idx[POSITION_BITS-1:0];
    quote = (c == QUOTE_SINGLE) || (c == QUOTE_DOUBLE);
    len   = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    // Shift the window; the newest character lands in the top slot. Whether
    // it may start a match depends on the quote flags before it toggles them.
    for (k = 0; k < PATTERN_MAX - 1; k++) begin
      win_char[k] = win_char[k+1];
      win_open[k] = win_open[k+1];
      win_pos[k]  = win_pos[k+1];
    end
    win_char[PATTERN_MAX-1] = c;
    win_open[PATTERN_MAX-1] = !quote && !in_sq && !in_dq;
    win_pos[PATTERN_MAX-1]  = pos;
    if (c == QUOTE_SINGLE) in_sq = !in_sq;
    if (c == QUOTE_DOUBLE) in_dq = !in_dq;
    // Only the start slot has to lie outside quotes; the rest need not.
    if (len != 0 && !hit) begin
      s = PATTERN_MAX - len;
      if (win_open[s]) begin
        same = 1'b1;
        for (j = 0; j < len; j++) begin
          if (win_char[s+j] != pat_bytes[8*j +: 8]) same = 1'b0;
        end
        if (same) begin
          hit     = 1'b1;
          hit_pos = win_pos[s];
        end
      end
    end
    if (char_idx <= POS_LIMIT) char_idx++;
    if (fin) begin
      r.found    = (len == 0) || hit;
      r.position = (len != 0 && hit) ? hit_pos : '0;
      r.too_long = over;
      match_q.push_back(r);
      clear_scan();
    end
  endtask

  // Monitor: take the transfers of all three channels at the rising edge.
  always @(posedge clk) begin : monitor
    result_t want;
    char_moved <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        writes_done++;
        case (cfg_index)
          CFG_PATTERN_LEN:   pat_len   = cfg_data[LEN_BITS-1:0];
          CFG_PATTERN_BYTES: pat_bytes = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        chars_taken++;
        scan_char(char_code, last_char);
      end
      if (out_valid && out_ready) begin
        if (match_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got found %0b position %0d too_long %0b",
                   $time, found, position, too_long);
        end else begin
          want = match_q.pop_front();
          results_checked++;
          if (found !== want.found) begin
            errors++;
            $display("%0t: found mismatch: expected %0b, got %0b", $time, want.found, found);
          end
          if (position !== want.position) begin
            errors++;
            $display("%0t: position mismatch: expected %0d, got %0d",
                     $time, want.position, position);
          end
          if (too_long !== want.too_long) begin
            errors++;
            $display("%0t: too_long mismatch: expected %0b, got %0b",
                     $time, want.too_long, too_long);
          end
        end
      end
    end
  end

  // Driver: hold the current character until its transfer, then offer the
  // next one or idle for a short random burst.
  always @(negedge clk) begin : driver
    text_char_t nxt;
    if (!in_valid || char_moved) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && text_q.size() != 0 && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (text_q.size() != 0) begin
        nxt = text_q.pop_front();
        char_code <= nxt.code;
        last_char <= nxt.is_last;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall in random bursts, and hold off for a long stretch
  // whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_char(input logic [CHAR_BITS-1:0] c, input logic fin);
    text_q.push_back('{code: c, is_last: fin});
    chars_pushed++;
    if (fin) strings_pushed++;
  endtask

  task automatic push_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) push_char(s[k], k == s.len() - 1);
  endtask

  // Mostly pattern-like letters and quotes, now and then any nonzero code.
  function automatic logic [CHAR_BITS-1:0] text_char();
    case ($urandom_range(0, 9))
      0:       return QUOTE_SINGLE;
      1:       return QUOTE_DOUBLE;
      2, 3:    return "a";
      4, 5:    return "b";
      6:       return "c";
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // One random string: plant the whole pattern, plant a copy that the end
  // of the string cuts short, or leave it as plain noise.
  task automatic push_random_string(input int eff);
    logic [CHAR_BITS-1:0] txt [$];
    int n, at, k;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
    for (k = 0; k < n; k++) txt.push_back(text_char());
    case ($urandom_range(0, 3))
      0, 1: begin
        if (eff != 0 && n >= eff) begin
          at = $urandom_range(0, n - eff);
          for (k = 0; k < eff; k++) txt[at+k] = pat_bytes[8*k +: 8];
        end
      end
      2: begin
        if (eff > 1 && n >= eff - 1) begin
          at = n - eff + 1;
          for (k = 0; k < eff - 1; k++) txt[at+k] = pat_bytes[8*k +: 8];
        end
      end
      default: ;
    endcase
    for (k = 0; k < n; k++) push_char(txt[k], k == n - 1);
  endtask

  // Wait until every character is taken and every result has come back.
  task automatic drain();
    while (chars_taken != chars_pushed || match_q.size() != 0) @(posedge clk);
  endtask

  // Drain, then let the block finish its last character before going on.
  task automatic settle();
    drain();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PAT_BITS-1:0] val;
    int ph, k, eff, base;
    clear_scan();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset pattern is length 1, byte 0: only a NUL character matches.
    push_text("a");
    push_char(8'h00, 1'b1);

    // Pattern "abc": quoted copy skipped, unquoted copy at 5; a string that
    // ends mid-match; a single quote opened inside double quotes stays open.
    settle();
    write_reg(CFG_PATTERN_LEN, 64'd3);
    write_reg(CFG_PATTERN_BYTES, 64'h63_62_61);
    push_text("'abc'abc");
    push_text("ab");
    push_text("\"'\"abc");

    // Pattern a, double quote, b: a match that starts outside quotes and
    // runs on into them.
    settle();
    write_reg(CFG_PATTERN_BYTES, 64'h62_22_61);
    push_text("ca\"b");

    // Empty pattern matches at position 0.
    settle();
    write_reg(CFG_PATTERN_LEN, 64'd0);
    push_text("q");

    // Oversized length acts as 8; all-ones pattern; spare indexes ignored.
    settle();
    write_reg(CFG_PATTERN_LEN, 64'd15);
    write_reg(CFG_PATTERN_BYTES, '1);
    write_reg(CFG_SPARE_A, '0);
    write_reg(CFG_SPARE_B, '0);
    push_char("x", 1'b0);
    for (k = 0; k < 8; k++) push_char(8'hFF, k == 7);

    // Hold the receiver off while one-character strings keep coming, so the
    // result buffer fills and the block stalls its input.
    settle();
    write_reg(CFG_PATTERN_LEN, 64'd1);
    write_reg(CFG_PATTERN_BYTES, 64'h61);
    hold_asked++;
    for (k = 0; k < 20; k++) push_char(text_char(), 1'b1);

    // Long strings: the last index just in range, then just past it, where
    // the match position saturates and too_long is raised.
    settle();
    write_reg(CFG_PATTERN_BYTES, 64'h5A);
    idle_on = 1'b0;
    for (k = 0; k < POS_LIMIT; k++) push_char("y", 1'b0);
    push_char("Z", 1'b1);
    for (k = 0; k < POS_LIMIT + 2; k++) push_char("y", 1'b0);
    push_char("Z", 1'b1);
    settle();
    idle_on = 1'b1;

    // Random phases, each with its own pattern; the last runs with no idling.
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      for (k = 0; k < PATTERN_MAX; k++) val[8*k +: 8] = text_char();
      if (ph == 4) val = '1;
      write_reg(CFG_PATTERN_LEN, 64'(phase_len[ph]));
      write_reg(CFG_PATTERN_BYTES, val);
      idle_on = (ph != PHASES - 1);
      eff  = (phase_len[ph] > PATTERN_MAX) ? PATTERN_MAX : phase_len[ph];
      base = chars_pushed;
      while (chars_pushed - base < 260) begin
        push_random_string(eff);
        // Now and then pause until every result is back.
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d characters in %0d strings, %0d results checked,",
             chars_taken, strings_pushed, results_checked);
    $display("%0d register writes across directed, stall, long-string and random phases.",
             writes_done);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results still owed", $time, match_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/qass_pkg.sv
sv/qass_out_buf.sv
sv/quote_aware_substring_search.sv
tb/sv/tb.sv
